// ===== hw/rtl/h264fua_pkg.sv =====
// shared types, constants and helper functions of the fu-a packetizer
`default_nettype none

package h264fua_pkg;

    // fu-a constants
    localparam logic [4:0] FU_A_TYPE    = 5'd28;
    localparam logic [7:0] NAL_REF_BITS = 8'h60;
    localparam logic [7:0] TYPE_MASK    = 8'h1F;
    localparam int         START_BIT    = 7;
    localparam int         END_BIT      = 6;
    localparam logic [7:0] START_PREFIX = 8'h01;

    // configuration
    localparam logic        REG_MAX_PACKET   = 1'b0;
    localparam logic [15:0] MAX_PACKET_RESET = 16'd1400;
    localparam logic [15:0] MIN_PACKET       = 16'd3;
    localparam logic [15:0] FU_HDR_BYTES     = 16'd2;

    // queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // work for the back end caused by one accepted byte
    typedef struct packed {
        logic [2:0] zero_count;
        logic       has_byte;
        logic [7:0] byte_val;
        logic       finish;
    } cmd_ctl_t;

    // descriptor fields other than the offset
    typedef struct packed {
        logic [7:0]  fu_indicator;
        logic [7:0]  fu_header;
        logic [15:0] payload_length;
        logic        run_last;
    } desc_hdr_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ZERO,
        OP_BYTE,
        OP_FINISH
    } op_kind_t;

    function automatic logic [7:0] fua_indicator(input logic [7:0] nal_hdr);
        fua_indicator = (nal_hdr & NAL_REF_BITS) | {3'b000, FU_A_TYPE};
    endfunction

    function automatic logic [7:0] fua_header(input logic s, input logic e,
                                              input logic [7:0] nal_hdr);
        logic [7:0] h;
        h = nal_hdr & TYPE_MASK;
        h[START_BIT] = s;
        h[END_BIT] = e;
        fua_header = h;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/h264fua_fifo.sv =====
// small register fifo used for the command queue and the descriptor queue
`default_nettype none

module h264fua_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/h264fua_front.sv =====
// front end: start code scan, zero holding and byte position tracking
`default_nettype none

module h264fua_front #(
    parameter int OFFSET_WIDTH = 24
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              stream_byte,
    input  wire logic                    buffer_end,
    input  wire logic                    cmd_full,
    output logic                         cmd_push,
    output h264fua_pkg::cmd_ctl_t        cmd_ctl,
    output logic [OFFSET_WIDTH-1:0]      cmd_pos
);

    logic                    seek_reg;
    logic                    seek_next;
    logic [1:0]              held_reg;
    logic [1:0]              held_next;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    logic                    accept;
    logic                    held_full;
    logic [1:0]              held_inc;

    assign in_stall  = cmd_full;
    assign accept    = in_valid && !cmd_full;
    assign held_full = (held_reg == 2'd3);
    assign held_inc  = held_full ? 2'd3 : held_reg + 2'd1;
    // first zero to commit always sits held_reg bytes back
    assign cmd_pos   = pos_reg - OFFSET_WIDTH'(held_reg);

    always_comb
    begin
        cmd_ctl   = '0;
        seek_next = seek_reg;
        held_next = held_reg;
        if (seek_reg)
        begin
            // skip leading zeros and then the unchecked prefix byte
            seek_next = (stream_byte == 8'h00);
            held_next = 2'd0;
        end
        else if (stream_byte == 8'h00)
        begin
            if (held_full)
            begin
                cmd_ctl.zero_count = buffer_end ? 3'd4 : 3'd1;
            end
            else
            begin
                cmd_ctl.zero_count = buffer_end ? {1'b0, held_inc} : 3'd0;
            end
            cmd_ctl.finish = buffer_end;
            held_next = held_inc;
        end
        else if (stream_byte == h264fua_pkg::START_PREFIX && held_reg[1])
        begin
            // start code: held zeros are dropped
            cmd_ctl.finish = 1'b1;
            held_next = 2'd0;
        end
        else
        begin
            cmd_ctl.zero_count = {1'b0, held_reg};
            cmd_ctl.has_byte   = 1'b1;
            cmd_ctl.byte_val   = stream_byte;
            cmd_ctl.finish     = buffer_end;
            held_next = 2'd0;
        end

        if (buffer_end)
        begin
            seek_next = 1'b1;
            held_next = 2'd0;
            pos_next  = '0;
        end
        else
        begin
            pos_next = pos_reg + OFFSET_WIDTH'(1);
        end
    end

    assign cmd_push = accept && !seek_reg &&
                      (cmd_ctl.zero_count != 3'd0 || cmd_ctl.has_byte || cmd_ctl.finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seek_reg <= 1'b1;
            held_reg <= 2'd0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            seek_reg <= seek_next;
            held_reg <= held_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/h264fua_back.sv =====
// back end: fragment sequencer, one commit or finish step per cycle while the descriptor queue has room
`default_nettype none

module h264fua_back #(
    parameter int OFFSET_WIDTH = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    input  wire h264fua_pkg::cmd_ctl_t       cmd_ctl,
    input  wire logic [OFFSET_WIDTH-1:0]     cmd_pos,
    output logic                             cmd_pop,
    input  wire logic [15:0]                 cap,
    input  wire logic                        desc_full,
    output logic                             desc_push,
    output h264fua_pkg::desc_hdr_t           desc_hdr,
    output logic [OFFSET_WIDTH-1:0]          desc_offset
);

    // current command
    logic                    cur_valid_reg;
    logic                    cur_valid_next;
    h264fua_pkg::cmd_ctl_t   cur_reg;
    h264fua_pkg::cmd_ctl_t   cur_next;
    logic [OFFSET_WIDTH-1:0] cur_pos_reg;
    logic [OFFSET_WIDTH-1:0] cur_pos_next;
    logic                    fin_e_reg;
    logic                    fin_e_next;

    // nal unit state
    logic                    body_reg;
    logic                    body_next;
    logic                    first_reg;
    logic                    first_next;
    logic [15:0]             fill_reg;
    logic [15:0]             fill_next;
    logic [7:0]              nal_hdr_reg;
    logic [7:0]              nal_hdr_next;
    logic [OFFSET_WIDTH-1:0] frag_off_reg;
    logic [OFFSET_WIDTH-1:0] frag_off_next;

    // last emitted descriptor, held until its run_last bit is known
    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    logic                    hold_final_reg;
    logic                    hold_final_next;
    h264fua_pkg::desc_hdr_t  hold_desc_reg;
    h264fua_pkg::desc_hdr_t  hold_desc_next;
    logic [OFFSET_WIDTH-1:0] hold_off_reg;
    logic [OFFSET_WIDTH-1:0] hold_off_next;

    h264fua_pkg::op_kind_t   op;
    logic                    go;
    logic                    op_end;
    logic                    emit;
    logic                    emit_s;
    logic                    emit_e;
    logic [15:0]             emit_len;
    logic [OFFSET_WIDTH-1:0] emit_off;
    logic [7:0]              commit_val;

    always_comb
    begin
        if (!cur_valid_reg)
        begin
            op = h264fua_pkg::OP_NONE;
        end
        else if (cur_reg.zero_count != 3'd0)
        begin
            op = h264fua_pkg::OP_ZERO;
        end
        else if (cur_reg.has_byte)
        begin
            op = h264fua_pkg::OP_BYTE;
        end
        else if (cur_reg.finish)
        begin
            op = h264fua_pkg::OP_FINISH;
        end
        else
        begin
            op = h264fua_pkg::OP_NONE;
        end
    end

    assign go         = cur_valid_reg && !desc_full;
    assign commit_val = (op == h264fua_pkg::OP_BYTE) ? cur_reg.byte_val : 8'h00;

    always_comb
    begin
        cur_next      = cur_reg;
        cur_pos_next  = cur_pos_reg;
        fin_e_next    = fin_e_reg;
        body_next     = body_reg;
        first_next    = first_reg;
        fill_next     = fill_reg;
        nal_hdr_next  = nal_hdr_reg;
        frag_off_next = frag_off_reg;
        op_end        = 1'b0;
        emit          = 1'b0;
        emit_s        = 1'b0;
        emit_e        = 1'b0;
        emit_len      = fill_reg;
        emit_off      = frag_off_reg;

        if (go)
        begin
            case (op)
                h264fua_pkg::OP_ZERO,
                h264fua_pkg::OP_BYTE:
                begin
                    if (!body_reg)
                    begin
                        // header byte opens the unit
                        nal_hdr_next  = commit_val;
                        frag_off_next = cur_pos_reg + OFFSET_WIDTH'(1);
                        fill_next     = 16'd0;
                        first_next    = 1'b1;
                        body_next     = 1'b1;
                    end
                    else if (fill_reg >= cap)
                    begin
                        // fragment full: close it, this byte opens the next
                        emit          = 1'b1;
                        emit_s        = first_reg;
                        frag_off_next = cur_pos_reg;
                        fill_next     = 16'd1;
                        first_next    = 1'b0;
                    end
                    else
                    begin
                        fill_next = fill_reg + 16'd1;
                    end
                    if (op == h264fua_pkg::OP_ZERO)
                    begin
                        cur_next.zero_count = cur_reg.zero_count - 3'd1;
                        cur_pos_next        = cur_pos_reg + OFFSET_WIDTH'(1);
                        op_end = (cur_reg.zero_count == 3'd1) && !cur_reg.has_byte &&
                                 !cur_reg.finish;
                    end
                    else
                    begin
                        cur_next.has_byte = 1'b0;
                        op_end = !cur_reg.finish;
                    end
                end
                h264fua_pkg::OP_FINISH:
                begin
                    if (fin_e_reg)
                    begin
                        // empty end packet after a single fragment unit
                        emit       = 1'b1;
                        emit_e     = 1'b1;
                        emit_len   = 16'd0;
                        fin_e_next = 1'b0;
                        op_end     = 1'b1;
                    end
                    else
                    begin
                        if (body_reg && first_reg)
                        begin
                            emit       = 1'b1;
                            emit_s     = 1'b1;
                            fin_e_next = 1'b1;
                        end
                        else if (body_reg)
                        begin
                            emit   = 1'b1;
                            emit_e = 1'b1;
                            op_end = 1'b1;
                        end
                        else
                        begin
                            op_end = 1'b1;
                        end
                        body_next  = 1'b0;
                        first_next = 1'b0;
                        fill_next  = 16'd0;
                    end
                end
                default:
                begin
                    op_end = 1'b1;
                end
            endcase
        end
    end

    // fetch the next command as the current one retires
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cmd_pop        = 1'b0;
        if (!cur_valid_reg || (go && op_end))
        begin
            cur_valid_next = cmd_valid;
            cmd_pop        = cmd_valid;
        end
    end

    always_comb
    begin
        desc_push       = hold_valid_reg && (emit || hold_final_reg) && !desc_full;
        desc_hdr        = hold_desc_reg;
        desc_hdr.run_last = hold_final_reg;
        desc_offset     = hold_off_reg;

        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        hold_desc_next  = hold_desc_reg;
        hold_off_next   = hold_off_reg;
        if (emit)
        begin
            hold_valid_next               = 1'b1;
            hold_final_next               = op_end;
            hold_desc_next.fu_indicator   = h264fua_pkg::fua_indicator(nal_hdr_reg);
            hold_desc_next.fu_header      = h264fua_pkg::fua_header(emit_s, emit_e, nal_hdr_reg);
            hold_desc_next.payload_length = emit_len;
            hold_desc_next.run_last       = op_end;
            hold_off_next                 = emit_off;
        end
        else if (desc_push)
        begin
            hold_valid_next = 1'b0;
            hold_final_next = 1'b0;
        end
        else if (go && op_end && hold_valid_reg)
        begin
            hold_final_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            fin_e_reg      <= 1'b0;
            body_reg       <= 1'b0;
            first_reg      <= 1'b0;
            fill_reg       <= 16'd0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            fin_e_reg      <= fin_e_next;
            body_reg       <= body_next;
            first_reg      <= first_next;
            fill_reg       <= fill_next;
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg     <= cmd_ctl;
            cur_pos_reg <= cmd_pos;
        end
        else
        begin
            cur_reg     <= cur_next;
            cur_pos_reg <= cur_pos_next;
        end
        nal_hdr_reg   <= nal_hdr_next;
        frag_off_reg  <= frag_off_next;
        hold_desc_reg <= hold_desc_next;
        hold_off_reg  <= hold_off_next;
    end

`ifndef SYNTHESIS
    // the empty end packet is only pending inside a finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_e_reg |-> (cur_valid_reg && cur_reg.zero_count == 3'd0 &&
                       !cur_reg.has_byte && cur_reg.finish))
        else $error("end packet pending outside a finish step");

    // no open unit means no partial fragment
    assert property (@(posedge clk) disable iff (!rst_n)
        !body_reg |-> (fill_reg == 16'd0))
        else $error("fragment fill without an open unit");

    // a held descriptor of unknown position belongs to the running command
    assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !hold_final_reg) |-> cur_valid_reg)
        else $error("held descriptor lost its command");

    // a pushed descriptor never lands in a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> !desc_full)
        else $error("descriptor pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/h264_fua_packetizer_unit.sv =====
// top level of the h.264 annex b to rtp fu-a descriptor packetizer
// path: the first descriptor of a request passes the command queue, fetch, step and hold
//   stage after the byte is accepted; each waits in hold for the next one
// throughput: one byte request per cycle while the command queue has room; the back end
//   takes one step per cycle unless desc_full, up to six for one byte (held zeros, byte, two finish steps)
// reset: asynchronous active low rst_n clears queues and scan state, loads 1400 as limit
`default_nettype none

module h264_fua_packetizer_unit #(
    parameter int OFFSET_WIDTH = 24
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // byte request channel
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              stream_byte,
    input  wire logic                    buffer_end,

    // descriptor request channel
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [7:0]                   fu_indicator,
    output logic [7:0]                   fu_header,
    output logic [OFFSET_WIDTH-1:0]      payload_offset,
    output logic [15:0]                  payload_length,
    output logic                         run_last,

    // configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CTL_W  = $bits(h264fua_pkg::cmd_ctl_t);
    localparam int HDR_W  = $bits(h264fua_pkg::desc_hdr_t);
    localparam int CMD_W  = OFFSET_WIDTH + CTL_W;
    localparam int DESC_W = OFFSET_WIDTH + HDR_W;

    // configuration registers
    logic [15:0] max_packet_reg;
    logic [15:0] cap_reg;
    logic        cfg_write;
    logic        cfg_hit;

    // front to command queue
    logic                    front_push;
    h264fua_pkg::cmd_ctl_t   front_ctl;
    logic [OFFSET_WIDTH-1:0] front_pos;
    logic                    cmd_full;
    logic                    cmd_empty;
    logic [CMD_W-1:0]        cmd_rdata;
    logic                    cmd_pop;
    h264fua_pkg::cmd_ctl_t   back_ctl;

    // back end to descriptor queue
    logic                    desc_push;
    h264fua_pkg::desc_hdr_t  desc_hdr;
    logic [OFFSET_WIDTH-1:0] desc_offset;
    logic                    desc_full;
    logic                    desc_empty;
    logic [DESC_W-1:0]       desc_rdata;
    h264fua_pkg::desc_hdr_t  out_hdr;

    // apb: no wait states, only one register
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == h264fua_pkg::REG_MAX_PACKET);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? {16'd0, max_packet_reg} : 32'd0;

    // payload cap kept ready, limits below three count as three
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_reg <= h264fua_pkg::MAX_PACKET_RESET;
            cap_reg        <= h264fua_pkg::MAX_PACKET_RESET - h264fua_pkg::FU_HDR_BYTES;
        end
        else if (cfg_write)
        begin
            max_packet_reg <= pwdata[15:0];
            if (pwdata[15:0] < h264fua_pkg::MIN_PACKET)
            begin
                cap_reg <= h264fua_pkg::MIN_PACKET - h264fua_pkg::FU_HDR_BYTES;
            end
            else
            begin
                cap_reg <= pwdata[15:0] - h264fua_pkg::FU_HDR_BYTES;
            end
        end
    end

    // front end classifies each byte into commit and finish work
    h264fua_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .buffer_end  (buffer_end),
        .cmd_full    (cmd_full),
        .cmd_push    (front_push),
        .cmd_ctl     (front_ctl),
        .cmd_pos     (front_pos)
    );

    // command queue decouples byte intake from fragment sequencing
    h264fua_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (h264fua_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data ({front_pos, front_ctl}),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rdata),
        .empty   (cmd_empty)
    );

    assign back_ctl = h264fua_pkg::cmd_ctl_t'(cmd_rdata[CTL_W-1:0]);

    // back end walks the commits and finishes, one step per cycle while the descriptor queue has room
    h264fua_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (!cmd_empty),
        .cmd_ctl     (back_ctl),
        .cmd_pos     (cmd_rdata[CMD_W-1:CTL_W]),
        .cmd_pop     (cmd_pop),
        .cap         (cap_reg),
        .desc_full   (desc_full),
        .desc_push   (desc_push),
        .desc_hdr    (desc_hdr),
        .desc_offset (desc_offset)
    );

    // descriptor queue absorbs bursts and parts the output side
    h264fua_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (h264fua_pkg::OUT_DEPTH)
    ) u_desc_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data ({desc_offset, desc_hdr}),
        .full    (desc_full),
        .rd_en   (!out_stall),
        .rd_data (desc_rdata),
        .empty   (desc_empty)
    );

    assign out_hdr        = h264fua_pkg::desc_hdr_t'(desc_rdata[HDR_W-1:0]);
    assign out_valid      = !desc_empty;
    assign fu_indicator   = out_hdr.fu_indicator;
    assign fu_header      = out_hdr.fu_header;
    assign payload_length = out_hdr.payload_length;
    assign run_last       = out_hdr.run_last;
    assign payload_offset = desc_rdata[DESC_W-1:HDR_W];

endmodule

`default_nettype wire

// ===== tb/fua_scoreboard_pkg.sv =====
// descriptor predictor and scoreboard for the fu-a packetizer testbench
`timescale 1ns / 1ps

package fua_scoreboard_pkg;

    localparam int OFS_BITS = 24;

    typedef struct packed {
        logic [7:0]          indicator;
        logic [7:0]          header;
        logic [OFS_BITS-1:0] offset;
        logic [15:0]         length;
        logic                last;
    } fua_desc_t;

    typedef enum logic [1:0] {
        SCAN_SEEK,
        SCAN_HEAD,
        SCAN_BODY
    } scan_state_t;

    class fua_scoreboard;
        scan_state_t         scan;
        int unsigned         zeros_held;
        logic [7:0]          nal_hdr;
        bit                  first_open;
        logic [OFS_BITS-1:0] frag_start;
        logic [15:0]         frag_fill;
        logic [OFS_BITS-1:0] next_pos;
        logic [15:0]         max_packet;

        fua_desc_t           expected_q[$];
        fua_desc_t           step_q[$];
        int unsigned         mismatches;
        int unsigned         descs_seen;
        int unsigned         bytes_seen;

        function new();
            max_packet = h264fua_pkg::MAX_PACKET_RESET;
            mismatches = 0;
            descs_seen = 0;
            bytes_seen = 0;
            clear_buffer_state();
        endfunction

        // state at reset and after every buffer end
        function void clear_buffer_state();
            scan       = SCAN_SEEK;
            zeros_held = 0;
            nal_hdr    = 8'h00;
            first_open = 1'b0;
            frag_start = '0;
            frag_fill  = 16'h0;
            next_pos   = '0;
        endfunction

        function void set_max_packet(logic [15:0] limit);
            max_packet = limit;
        endfunction

        function logic [15:0] payload_cap();
            logic [15:0] r;
            r = max_packet;
            if (r < h264fua_pkg::MIN_PACKET)
                r = h264fua_pkg::MIN_PACKET;
            return r - h264fua_pkg::FU_HDR_BYTES;
        endfunction

        function void push_desc(bit s, bit e, logic [OFS_BITS-1:0] off, logic [15:0] len);
            fua_desc_t d;
            d.indicator = (nal_hdr & h264fua_pkg::NAL_REF_BITS) |
                          {3'b000, h264fua_pkg::FU_A_TYPE};
            d.header    = {s, e, 1'b0, nal_hdr[4:0]};
            d.offset    = off;
            d.length    = len;
            d.last      = 1'b0;
            step_q.push_back(d);
        endfunction

        // one byte that belongs to the current unit
        function void take_byte(logic [7:0] v, logic [OFS_BITS-1:0] pos);
            if (scan == SCAN_HEAD)
            begin
                nal_hdr    = v;
                frag_start = pos + 1'b1;
                frag_fill  = 16'h0;
                first_open = 1'b1;
                scan       = SCAN_BODY;
                return;
            end
            if (frag_fill >= payload_cap())
            begin
                push_desc(first_open, 1'b0, frag_start, frag_fill);
                frag_start = pos;
                frag_fill  = 16'h0;
                first_open = 1'b0;
            end
            frag_fill = frag_fill + 16'h1;
        endfunction

        function void close_unit();
            if (scan == SCAN_BODY)
            begin
                if (first_open)
                begin
                    push_desc(1'b1, 1'b0, frag_start, frag_fill);
                    push_desc(1'b0, 1'b1, frag_start, 16'h0);
                end
                else
                begin
                    push_desc(1'b0, 1'b1, frag_start, frag_fill);
                end
            end
            scan       = SCAN_HEAD;
            zeros_held = 0;
            first_open = 1'b0;
            frag_fill  = 16'h0;
        endfunction

        // accepted byte request: predict the descriptors it releases
        function void note_byte(logic [7:0] b, logic last);
            logic [OFS_BITS-1:0] pos;
            int unsigned k;
            pos = next_pos;
            step_q.delete();
            bytes_seen++;
            if (scan == SCAN_SEEK)
            begin
                if (b != 8'h00)
                begin
                    scan       = SCAN_HEAD;
                    zeros_held = 0;
                end
            end
            else if (b == 8'h00)
            begin
                if (zeros_held >= 3)
                begin
                    zeros_held = 3;
                    take_byte(8'h00, pos - OFS_BITS'(3));
                end
                else
                begin
                    zeros_held++;
                end
            end
            else if (b == h264fua_pkg::START_PREFIX && zeros_held >= 2)
            begin
                close_unit();
            end
            else
            begin
                for (k = zeros_held; k > 0; k--)
                    take_byte(8'h00, pos - OFS_BITS'(k));
                zeros_held = 0;
                take_byte(b, pos);
            end

            if (last)
            begin
                if (scan != SCAN_SEEK)
                begin
                    for (k = zeros_held; k > 0; k--)
                        take_byte(8'h00, pos - OFS_BITS'(k) + OFS_BITS'(1));
                    zeros_held = 0;
                    close_unit();
                end
                clear_buffer_state();
            end
            else
            begin
                next_pos = pos + 1'b1;
            end

            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // accepted descriptor request: compare with the oldest prediction
        function void check_desc(fua_desc_t got);
            fua_desc_t want;
            descs_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected descriptor: ind 0x%0h hdr 0x%0h off 0x%0h len %0d",
                       got.indicator, got.header, got.offset, got.length);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("fu_indicator", want.indicator, got.indicator);
            compare_field("fu_header", want.header, got.header);
            compare_field("payload_offset", want.offset, got.offset);
            compare_field("payload_length", want.length, got.length);
            compare_field("run_last", want.last, got.last);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ===== tb/testbench.sv =====
// top-level testbench of the fu-a packetizer: directed and random byte streams
`timescale 1ns / 1ps

module testbench;

    // cycles without any accepted request before the run is declared hung;
    // the long output hold is far below this
    localparam int STALL_LIMIT   = 4000;
    // output hold that lets the byte queue fill up and stall the sender
    localparam int LONG_HOLD     = 300;
    // cycles after the last descriptor so that resultless requests can drain
    localparam int SETTLE_CYCLES = 40;
    localparam logic [2:0] MAX_PACKET_ADDR = {h264fua_pkg::REG_MAX_PACKET, 2'b00};

    logic clk = 1'b0;
    logic rst_n;

    logic                                    in_valid;
    logic                                    in_stall;
    logic [7:0]                              stream_byte;
    logic                                    buffer_end;
    logic                                    out_valid;
    logic                                    out_stall;
    logic [7:0]                              fu_indicator;
    logic [7:0]                              fu_header;
    logic [fua_scoreboard_pkg::OFS_BITS-1:0] payload_offset;
    logic [15:0]                             payload_length;
    logic                                    run_last;
    logic                                    psel;
    logic                                    penable;
    logic                                    pwrite;
    logic [2:0]                              paddr;
    logic [31:0]                             pwdata;
    logic [31:0]                             prdata;
    logic                                    pready;

    fua_scoreboard_pkg::fua_scoreboard sb = new();

    // idle chances in percent per cycle for the sending and receiving sides
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // each increment asks the receiver for one long hold
    int unsigned hold_requests = 0;
    int unsigned items_sent = 0;
    // bytes of the buffer being built
    logic [7:0]  run_q[$];

    always #5 clk = ~clk;

    h264_fua_packetizer_unit #(
        .OFFSET_WIDTH(fua_scoreboard_pkg::OFS_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .stream_byte   (stream_byte),
        .buffer_end    (buffer_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fu_indicator  (fu_indicator),
        .fu_header     (fu_header),
        .payload_offset(payload_offset),
        .payload_length(payload_length),
        .run_last      (run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // one byte request: random idle cycles first, then hold it until accepted;
    // valid stays high on return so a following request can go back to back
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        buffer_end  <= last;
        @(posedge clk);
        // values read here are the ones the edge sampled
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_byte(b, last);
        items_sent++;
    endtask

    // send the built bytes, flagging the final one as buffer end if asked
    task automatic send_run(input logic close_buffer);
        for (int i = 0; i < run_q.size(); i++)
            send_byte(run_q[i], close_buffer && (i == run_q.size() - 1));
        run_q.delete();
    endtask

    // stop offering, wait until every predicted descriptor came out, then let
    // requests that cause no descriptor work their way through the block
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write with a setup and an access phase; only called with the block idle
    task automatic write_max_packet(input logic [15:0] limit);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_PACKET_ADDR;
        pwdata  <= {16'h0000, limit};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        sb.set_max_packet(limit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // build and send one random buffer; mostly well-formed annex b with
    // random unit content, sometimes noise or a buffer of zeros
    task automatic play_buffer();
        int unsigned kind;
        int unsigned units;
        int unsigned body;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // noise, zero heavy so that odd start code shapes appear
            repeat ($urandom_range(1, 6))
                run_q.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
        else if (kind < 12)
        begin
            // buffer of zeros only
            repeat ($urandom_range(1, 4)) run_q.push_back(8'h00);
        end
        else
        begin
            // leading zeros and the byte that is skipped unchecked
            repeat ($urandom_range(0, 3)) run_q.push_back(8'h00);
            run_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h01);
            units = $urandom_range(1, 3);
            for (int u = 0; u < units; u++)
            begin
                if (u > 0)
                begin
                    // four-byte start code now and then, its extra zero is dropped
                    if ($urandom_range(0, 3) == 0)
                        run_q.push_back(8'h00);
                    run_q.push_back(8'h00);
                    run_q.push_back(8'h00);
                    run_q.push_back(8'h01);
                    // empty unit: a second start code right away
                    if ($urandom_range(0, 9) == 0)
                    begin
                        run_q.push_back(8'h00);
                        run_q.push_back(8'h00);
                        run_q.push_back(8'h01);
                    end
                end
                run_q.push_back(8'($urandom_range(0, 255)));
                body = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
                repeat (body)
                    run_q.push_back(($urandom_range(0, 99) < 35) ? 8'h00
                                                                 : 8'($urandom_range(1, 255)));
            end
            // trailing zeros belong to the last unit
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3)) run_q.push_back(8'h00);
        end
        send_run(1'b1);
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < quota)
            play_buffer();
    endtask

    // receiver: check every accepted descriptor, then pick the next stall;
    // a long hold is counted here while the sender keeps offering bytes
    initial
    begin
        int unsigned                   hold_left;
        int unsigned                   holds_served;
        fua_scoreboard_pkg::fua_desc_t got;
        hold_left    = 0;
        holds_served = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.indicator = fu_indicator;
                got.header    = fu_header;
                got.offset    = payload_offset;
                got.length    = payload_length;
                got.last      = run_last;
                sb.check_desc(got);
            end
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // watchdog: ends the run after too many cycles with no request accepted
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        stream_byte   = 8'h00;
        buffer_end    = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'b000;
        pwdata        = 32'h0;
        send_idle_pct = 33;
        recv_idle_pct = 57;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset limit of 1400: single fragment unit, four-byte start
        // code, header-only unit, empty unit, trailing zeros at buffer end
        run_q = '{8'h00, 8'h01, 8'hE5, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
                  8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00};
        send_run(1'b1);
        // buffer of a single zero, then one that ends on the skipped byte
        run_q = '{8'h00};
        send_run(1'b1);
        run_q = '{8'h01};
        send_run(1'b1);
        wait_for_idle();

        // largest limit, fill a fragment, then drop to the smallest limit
        // mid-fragment: the overfull fragment goes out at its current fill
        write_max_packet(16'hFFFF);
        run_q = '{8'h00, 8'h01, 8'h41, 8'h11, 8'h22, 8'h33, 8'h44};
        send_run(1'b0);
        wait_for_idle();
        write_max_packet(h264fua_pkg::MIN_PACKET);
        run_q = '{8'h55};
        send_run(1'b1);
        wait_for_idle();

        // random, sender idles less than receiver; one mid-phase pause
        write_max_packet(16'd6);
        run_phase(70);
        wait_for_idle();
        run_phase(70);
        wait_for_idle();

        // random, the other way round, limit below the minimum
        send_idle_pct = 57;
        recv_idle_pct = 33;
        write_max_packet(16'd2);
        run_phase(130);
        wait_for_idle();

        // random at full rate, with one long output hold to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_packet(16'd10);
        hold_requests <= hold_requests + 1;
        run_phase(130);
        wait_for_idle();

        $display("run covered %0d byte requests and %0d descriptors", sb.bytes_seen,
                 sb.descs_seen);
        $display("limits 1400, 65535, 3, 6, 2 and 10, with idle gaps, a long hold and drains");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
